// ----- rtl/tccw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants of the text console character writer: word
// layouts of the input and result channels and the decoded command word.
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int COL_FW  = 7;
  localparam int ROW_FW  = 5;
  localparam int IDX_FW  = 11;
  localparam int CELL_W  = CHAR_W + ATTR_W;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd15;
  localparam int                KEEP_ROWS  = 2;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BEL   = 8'h07;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_LF,
    CMD_CR,
    CMD_BS,
    CMD_FF,
    CMD_PUT,
    CMD_TAB,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    logic              op;
    logic [CHAR_W-1:0] char_code;
    logic [COL_FW-1:0] read_col;
    logic [ROW_FW-1:0] read_row;
  } item_t;

  typedef struct packed {
    logic [COL_FW-1:0] cursor_col;
    logic [ROW_FW-1:0] cursor_row;
    logic [IDX_FW-1:0] cursor_index;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
  } result_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CHAR_W-1:0] ch;
    logic [COL_FW-1:0] read_col;
    logic [ROW_FW-1:0] read_row;
    logic              read_ok;
  } cmd_t;

endpackage

// ----- rtl/tccw_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_stream_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface tccw_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ----- rtl/tccw_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_front
// Accepts input words and decodes them into command words for the queue.
// ----------------------------------------------------------------------------
module tccw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic          hold,
  tccw_stream_if.sink   item,
  tccw_stream_if.source cmd
);

  localparam logic [tccw_pkg::COL_FW:0]   COL_LIMIT = (tccw_pkg::COL_FW + 1)'(COLUMNS);
  localparam logic [tccw_pkg::ROW_FW+1:0] ROW_LIMIT = (tccw_pkg::ROW_FW + 2)'(ROWS);

  tccw_pkg::item_t item_w;
  tccw_pkg::cmd_t  cmd_w;

  assign item_w = item.payload;

  always_comb begin
    cmd_w          = '0;
    cmd_w.ch       = item_w.char_code;
    cmd_w.read_col = item_w.read_col;
    cmd_w.read_row = item_w.read_row;
    cmd_w.read_ok  = ({1'b0, item_w.read_col} < COL_LIMIT) &&
                     ({2'b00, item_w.read_row} < ROW_LIMIT);
    if (item_w.op == tccw_pkg::OP_READ) begin
      cmd_w.kind = tccw_pkg::CMD_READ;
    end else begin
      case (item_w.char_code)
        tccw_pkg::CH_NUL: cmd_w.kind = tccw_pkg::CMD_NOP;
        tccw_pkg::CH_BEL: cmd_w.kind = tccw_pkg::CMD_NOP;
        tccw_pkg::CH_LF:  cmd_w.kind = tccw_pkg::CMD_LF;
        tccw_pkg::CH_CR:  cmd_w.kind = tccw_pkg::CMD_CR;
        tccw_pkg::CH_TAB: cmd_w.kind = tccw_pkg::CMD_TAB;
        tccw_pkg::CH_FF:  cmd_w.kind = tccw_pkg::CMD_FF;
        tccw_pkg::CH_BS:  cmd_w.kind = tccw_pkg::CMD_BS;
        default:          cmd_w.kind = tccw_pkg::CMD_PUT;
      endcase
    end
  end

  assign cmd.payload = cmd_w;
  assign cmd.valid   = item.valid && !hold;
  assign item.ready  = cmd.ready && !hold;

endmodule

// ----- rtl/tccw_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_queue
// Short command queue between decode and execution.
// ----------------------------------------------------------------------------
module tccw_queue (
  input  logic          clk,
  input  logic          rst,
  tccw_stream_if.sink   push,
  tccw_stream_if.source pop
);

  tccw_pkg::cmd_t                slots [tccw_pkg::QDEPTH];
  logic [tccw_pkg::QPTR_W-1:0]   wr_ptr;
  logic [tccw_pkg::QPTR_W-1:0]   rd_ptr;
  logic [tccw_pkg::QPTR_W:0]     count;
  logic                          do_push;
  logic                          do_pop;

  assign push.ready  = count != (tccw_pkg::QPTR_W + 1)'(tccw_pkg::QDEPTH);
  assign pop.valid   = count != '0;
  assign pop.payload = slots[rd_ptr];
  assign do_push     = push.valid && push.ready;
  assign do_pop      = pop.valid && pop.ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/tccw_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_back
// Executes commands: screen memory, cursor, scroll and clear sweeps, and the
// result register.
// ----------------------------------------------------------------------------
module tccw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [tccw_pkg::ATTR_W-1:0]   text_attr,
  output logic                          init_busy,
  tccw_stream_if.sink                   cmd,
  tccw_stream_if.source                 result
);

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = 2 ** ADDR_W;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
  localparam logic [ROW_W-1:0] ROW_PEN  = ROW_W'(ROWS - 2);
  localparam logic [ROW_W-1:0] ROW_HOME = ROW_W'(tccw_pkg::KEEP_ROWS);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PUT,
    S_NEXT,
    S_SCROLL,
    S_DRAIN,
    S_FILL,
    S_RDWAIT,
    S_DONE
  } state_t;

  state_t                          state;
  logic [COL_W-1:0]                col;
  logic [ROW_W-1:0]                row;
  logic [COL_W-1:0]                cnt_col;
  logic [ROW_W-1:0]                cnt_row;
  logic                            pend_valid;
  logic [ADDR_W-1:0]               pend_addr;
  logic [1:0]                      tab_left;
  logic [tccw_pkg::CHAR_W-1:0]     put_ch;
  logic [tccw_pkg::ATTR_W-1:0]     clr_attr;
  logic                            clr_reply;
  logic [tccw_pkg::CHAR_W-1:0]     res_char;
  logic [tccw_pkg::ATTR_W-1:0]     res_attr;
  logic                            out_valid;
  tccw_pkg::result_t               out_data;

  logic [tccw_pkg::CELL_W-1:0]     mem [DEPTH];
  logic [tccw_pkg::CELL_W-1:0]     mem_q;
  logic                            rd_en;
  logic [ADDR_W-1:0]               rd_addr;
  logic                            wr_en;
  logic [ADDR_W-1:0]               wr_addr;
  logic [tccw_pkg::CELL_W-1:0]     wr_data;
  tccw_pkg::cmd_t                  c;

  assign c              = cmd.payload;
  assign cmd.ready      = state == S_IDLE;
  assign init_busy      = (state == S_CLEAR) && !clr_reply;
  assign result.valid   = out_valid;
  assign result.payload = out_data;

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {ROW_W'(c.read_row), COL_W'(c.read_col)};
    wr_en   = 1'b0;
    wr_addr = {row, col};
    wr_data = {text_attr, put_ch};
    case (state)
      S_IDLE: begin
        rd_en = cmd.valid;
      end
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = {cnt_row, cnt_col};
        wr_data = {clr_attr, tccw_pkg::CH_SPACE};
      end
      S_PUT: begin
        wr_en = 1'b1;
      end
      S_SCROLL: begin
        rd_en   = 1'b1;
        rd_addr = {cnt_row + 1'b1, cnt_col};
        wr_en   = pend_valid;
        wr_addr = pend_addr;
        wr_data = {text_attr, mem_q[tccw_pkg::CHAR_W-1:0]};
      end
      S_DRAIN: begin
        wr_en   = pend_valid;
        wr_addr = pend_addr;
        wr_data = {text_attr, mem_q[tccw_pkg::CHAR_W-1:0]};
      end
      S_FILL: begin
        wr_en   = 1'b1;
        wr_addr = {ROW_LAST, cnt_col};
        wr_data = {text_attr, tccw_pkg::CH_SPACE};
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      col        <= '0;
      row        <= ROW_HOME;
      cnt_col    <= '0;
      cnt_row    <= '0;
      pend_valid <= 1'b0;
      tab_left   <= '0;
      clr_attr   <= tccw_pkg::RESET_ATTR;
      clr_reply  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && result.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (cnt_col == COL_LAST) begin
            cnt_col <= '0;
            if (cnt_row == ROW_LAST) begin
              col   <= '0;
              row   <= ROW_HOME;
              state <= clr_reply ? S_DONE : S_IDLE;
            end else begin
              cnt_row <= cnt_row + 1'b1;
            end
          end else begin
            cnt_col <= cnt_col + 1'b1;
          end
        end
        S_IDLE: begin
          if (cmd.valid) begin
            res_char <= '0;
            res_attr <= '0;
            case (c.kind)
              tccw_pkg::CMD_CR: begin
                col   <= '0;
                state <= S_DONE;
              end
              tccw_pkg::CMD_BS: begin
                if (col != '0) begin
                  col <= col - 1'b1;
                end
                state <= S_DONE;
              end
              tccw_pkg::CMD_LF: begin
                col <= '0;
                if (row == ROW_LAST) begin
                  cnt_row    <= ROW_HOME;
                  cnt_col    <= '0;
                  pend_valid <= 1'b0;
                  state      <= S_SCROLL;
                end else begin
                  row   <= row + 1'b1;
                  state <= S_NEXT;
                end
              end
              tccw_pkg::CMD_PUT: begin
                put_ch <= c.ch;
                state  <= S_PUT;
              end
              tccw_pkg::CMD_TAB: begin
                put_ch   <= tccw_pkg::CH_SPACE;
                tab_left <= 2'd3;
                state    <= S_PUT;
              end
              tccw_pkg::CMD_FF: begin
                cnt_row   <= '0;
                cnt_col   <= '0;
                clr_attr  <= text_attr;
                clr_reply <= 1'b1;
                state     <= S_CLEAR;
              end
              tccw_pkg::CMD_READ: begin
                state <= c.read_ok ? S_RDWAIT : S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_PUT: begin
          if (col == COL_LAST) begin
            col <= '0;
            if (row == ROW_LAST) begin
              cnt_row    <= ROW_HOME;
              cnt_col    <= '0;
              pend_valid <= 1'b0;
              state      <= S_SCROLL;
            end else begin
              row   <= row + 1'b1;
              state <= S_NEXT;
            end
          end else begin
            col   <= col + 1'b1;
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (tab_left != '0) begin
            tab_left <= tab_left - 1'b1;
            state    <= S_PUT;
          end else begin
            state <= S_DONE;
          end
        end
        S_SCROLL: begin
          pend_valid <= 1'b1;
          pend_addr  <= {cnt_row, cnt_col};
          if (cnt_col == COL_LAST) begin
            cnt_col <= '0;
            if (cnt_row == ROW_PEN) begin
              state <= S_DRAIN;
            end else begin
              cnt_row <= cnt_row + 1'b1;
            end
          end else begin
            cnt_col <= cnt_col + 1'b1;
          end
        end
        S_DRAIN: begin
          pend_valid <= 1'b0;
          cnt_col    <= '0;
          state      <= S_FILL;
        end
        S_FILL: begin
          if (cnt_col == COL_LAST) begin
            state <= S_NEXT;
          end else begin
            cnt_col <= cnt_col + 1'b1;
          end
        end
        S_RDWAIT: begin
          res_char <= mem_q[tccw_pkg::CHAR_W-1:0];
          res_attr <= mem_q[tccw_pkg::CELL_W-1:tccw_pkg::CHAR_W];
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            out_valid              <= 1'b1;
            out_data.cursor_col    <= tccw_pkg::COL_FW'(col);
            out_data.cursor_row    <= tccw_pkg::ROW_FW'(row);
            out_data.cursor_index  <= tccw_pkg::IDX_FW'(int'(row) * COLUMNS + int'(col));
            out_data.cell_char     <= res_char;
            out_data.cell_attr     <= res_attr;
            clr_reply              <= 1'b0;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/text_console_char_writer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer
// Character writer for a text console screen with cursor, scroll and clear.
// ----------------------------------------------------------------------------
// Every accepted word returns one result word with the cursor position and,
// for a read, the addressed cell. Words are decoded into a two-entry command
// queue and executed one at a time against a single-port-write screen memory,
// one cell per cycle. Running past the bottom row adds a scroll, and a form
// feed a clear of the whole screen. After reset the same clear runs with no
// words accepted; the attribute register can be written during it.
// ----------------------------------------------------------------------------
module text_console_char_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [tccw_pkg::ATTR_W-1:0] cfg_wdata,
  tccw_stream_if.sink                 item,
  tccw_stream_if.source               result
);

  logic [tccw_pkg::ATTR_W-1:0] text_attr;
  logic                        init_busy;

  tccw_stream_if #(.payload_t(tccw_pkg::cmd_t)) front_q ();
  tccw_stream_if #(.payload_t(tccw_pkg::cmd_t)) q_back ();

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr <= tccw_pkg::RESET_ATTR;
    end else if (cfg_we) begin
      text_attr <= cfg_wdata;
    end
  end

  tccw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .hold (init_busy),
    .item (item),
    .cmd  (front_q)
  );

  tccw_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (front_q),
    .pop  (q_back)
  );

  tccw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .text_attr (text_attr),
    .init_busy (init_busy),
    .cmd       (q_back),
    .result    (result)
  );

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (int'(result.payload.cursor_col) < COLUMNS))
    else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (int'(result.payload.cursor_row) < ROWS))
    else $error("cursor row out of range");

  a_init_hold: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !item.ready)
    else $error("word taken during screen init");

endmodule

// ----- dv/tb_text_console_char_writer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_char_writer
// Self-checking testbench for the text console character writer.
// ----------------------------------------------------------------------------
// Words go through the item channel and every result word is checked, field
// by field, against a cycle-free model of the screen, the cursor and the
// attribute register kept in a small scoreboard class. A directed burst
// covers the control bytes, the field extremes and reads outside the screen.
// Random bursts follow under several attribute values. The sender and the
// receiver stall at random, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_text_console_char_writer;

  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int CELLS        = COLUMNS * ROWS;
  localparam int DRAIN_CYCLES = 2200;
  localparam int LIMIT_CYCLES = 10_000_000;

  class console_scoreboard;
    logic [tccw_pkg::CELL_W-1:0] screen [CELLS];
    int                          cur_col;
    int                          cur_row;
    logic [tccw_pkg::ATTR_W-1:0] attr;
    tccw_pkg::result_t           expected_q[$];
    int                          errors;

    function new();
      attr   = tccw_pkg::RESET_ATTR;
      errors = 0;
      clear_screen();
    endfunction

    function void clear_screen();
      for (int i = 0; i < CELLS; i++) screen[i] = {attr, tccw_pkg::CH_SPACE};
      cur_col = 0;
      cur_row = tccw_pkg::KEEP_ROWS;
    endfunction

    function void scroll_up();
      for (int r = tccw_pkg::KEEP_ROWS; r + 1 < ROWS; r++)
        for (int c = 0; c < COLUMNS; c++)
          screen[r*COLUMNS+c] = {attr, screen[(r+1)*COLUMNS+c][tccw_pkg::CHAR_W-1:0]};
      for (int c = 0; c < COLUMNS; c++)
        screen[(ROWS-1)*COLUMNS+c] = {attr, tccw_pkg::CH_SPACE};
    endfunction

    function void put_char(logic [tccw_pkg::CHAR_W-1:0] ch);
      case (ch)
        tccw_pkg::CH_NUL, tccw_pkg::CH_BEL: begin
        end
        tccw_pkg::CH_LF: begin
          cur_col = 0;
          cur_row++;
        end
        tccw_pkg::CH_CR: cur_col = 0;
        tccw_pkg::CH_TAB: begin
          repeat (4) put_char(tccw_pkg::CH_SPACE);
        end
        tccw_pkg::CH_FF: clear_screen();
        tccw_pkg::CH_BS: begin
          if (cur_col > 0) cur_col--;
        end
        default: begin
          screen[cur_row*COLUMNS+cur_col] = {attr, ch};
          cur_col++;
        end
      endcase
      if (cur_col > COLUMNS - 1) begin
        cur_col = 0;
        cur_row++;
      end
      if (cur_row > ROWS - 1) begin
        scroll_up();
        cur_row = ROWS - 1;
      end
    endfunction

    function void note_item(tccw_pkg::item_t it);
      tccw_pkg::result_t r;
      r = '0;
      if (it.op == tccw_pkg::OP_PUT) begin
        put_char(it.char_code);
      end else if (int'(it.read_col) < COLUMNS && int'(it.read_row) < ROWS) begin
        {r.cell_attr, r.cell_char} = screen[int'(it.read_row)*COLUMNS + int'(it.read_col)];
      end
      r.cursor_col   = tccw_pkg::COL_FW'(cur_col);
      r.cursor_row   = tccw_pkg::ROW_FW'(cur_row);
      r.cursor_index = tccw_pkg::IDX_FW'(cur_row * COLUMNS + cur_col);
      expected_q.push_back(r);
    endfunction

    function void check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(tccw_pkg::result_t got);
      tccw_pkg::result_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual %h", $time, got);
        return;
      end
      exp_r = expected_q.pop_front();
      check_field("cursor_col", int'(exp_r.cursor_col), int'(got.cursor_col));
      check_field("cursor_row", int'(exp_r.cursor_row), int'(got.cursor_row));
      check_field("cursor_index", int'(exp_r.cursor_index), int'(got.cursor_index));
      check_field("cell_char", int'(exp_r.cell_char), int'(got.cell_char));
      check_field("cell_attr", int'(exp_r.cell_attr), int'(got.cell_attr));
    endfunction
  endclass

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [tccw_pkg::ATTR_W-1:0] cfg_wdata;

  tccw_stream_if #(.payload_t(tccw_pkg::item_t))   item_if ();
  tccw_stream_if #(.payload_t(tccw_pkg::result_t)) result_if ();

  console_scoreboard sb;
  int                tx_idle_pct;
  int                rx_idle_pct;
  int                hold_req;
  int                hold_cnt;
  longint            cycles;

  text_console_char_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .item     (item_if.sink),
    .result   (result_if.source)
  );

  initial begin
    clk               = 1'b0;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    item_if.valid     = 1'b0;
    item_if.payload   = '0;
    result_if.ready   = 1'b0;
    tx_idle_pct       = 28;
    rx_idle_pct       = 78;
    hold_req          = 0;
    hold_cnt          = 0;
    cycles            = 0;
    sb                = new();
  end

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("text_console_char_writer verification failed");
      $finish;
    end
  end

  // receiver: checks accepted words and drives ready for the next cycle
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) sb.check_result(result_if.payload);
    if (hold_cnt > 0) begin
      result_if.ready <= 1'b0;
      hold_cnt = hold_cnt - 1;
    end else if (hold_req > 0) begin
      result_if.ready <= 1'b0;
      hold_cnt = hold_req - 1;
      hold_req = 0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic tccw_pkg::item_t put_word(logic [tccw_pkg::CHAR_W-1:0] ch);
    tccw_pkg::item_t it;
    it.op        = tccw_pkg::OP_PUT;
    it.char_code = ch;
    it.read_col  = tccw_pkg::COL_FW'($urandom_range(127));
    it.read_row  = tccw_pkg::ROW_FW'($urandom_range(31));
    return it;
  endfunction

  function automatic tccw_pkg::item_t read_word(int col, int row);
    tccw_pkg::item_t it;
    it.op        = tccw_pkg::OP_READ;
    it.char_code = tccw_pkg::CHAR_W'($urandom_range(255));
    it.read_col  = tccw_pkg::COL_FW'(col);
    it.read_row  = tccw_pkg::ROW_FW'(row);
    return it;
  endfunction

  function automatic tccw_pkg::item_t random_word();
    tccw_pkg::item_t it;
    int              pick;
    it   = put_word(tccw_pkg::CHAR_W'($urandom_range(255)));
    pick = $urandom_range(99);
    if (pick < 20) begin
      if ($urandom_range(9) != 0) it = read_word($urandom_range(COLUMNS-1), $urandom_range(ROWS-1));
      else it = read_word($urandom_range(127), $urandom_range(31));
    end else if (pick < 24) begin
      it.char_code = tccw_pkg::CH_LF;
    end else if (pick < 26) begin
      it.char_code = tccw_pkg::CH_CR;
    end else if (pick < 29) begin
      it.char_code = tccw_pkg::CH_BS;
    end else if (pick < 32) begin
      it.char_code = tccw_pkg::CH_TAB;
    end else if (pick < 33) begin
      it.char_code = tccw_pkg::CH_FF;
    end
    return it;
  endfunction

  task automatic send_word(input tccw_pkg::item_t it);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk);
    end
    item_if.valid   <= 1'b1;
    item_if.payload <= it;
    do @(posedge clk); while (!item_if.ready);
    sb.note_item(it);
  endtask

  task automatic wait_idle();
    item_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_attr(input logic [tccw_pkg::ATTR_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.attr = value;
    cfg_we <= 1'b0;
  endtask

  task automatic random_burst(input int count);
    repeat (count) send_word(random_word());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_word(read_word(0, 0));
    send_word(read_word(COLUMNS-1, ROWS-1));
    send_word(read_word(127, 31));
    send_word(read_word(COLUMNS, 0));
    send_word(read_word(0, ROWS));
    send_word(put_word(8'h41));
    send_word(put_word(8'hFF));
    send_word(read_word(0, tccw_pkg::KEEP_ROWS));
    send_word(read_word(1, tccw_pkg::KEEP_ROWS));
    send_word(put_word(tccw_pkg::CH_NUL));
    send_word(put_word(tccw_pkg::CH_BEL));
    send_word(put_word(tccw_pkg::CH_BS));
    send_word(put_word(tccw_pkg::CH_BS));
    send_word(put_word(tccw_pkg::CH_BS));
    send_word(put_word(tccw_pkg::CH_TAB));
    send_word(put_word(tccw_pkg::CH_CR));
    send_word(put_word(tccw_pkg::CH_LF));
    send_word(put_word(8'h80));
    send_word(put_word(tccw_pkg::CH_FF));
    send_word(read_word(0, tccw_pkg::KEEP_ROWS + 1));
    send_word(put_word(8'h7F));

    write_attr(8'h00);
    random_burst(260);

    write_attr(8'hFF);
    tx_idle_pct = 78;
    rx_idle_pct = 28;
    random_burst(260);

    write_attr(tccw_pkg::ATTR_W'($urandom_range(255)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 600;
    random_burst(260);

    write_attr(tccw_pkg::ATTR_W'($urandom_range(255)));
    random_burst(250);

    wait_idle();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("text_console_char_writer verification clean");
    end else begin
      $display("text_console_char_writer verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/tccw_pkg.sv
rtl/tccw_stream_if.sv
rtl/tccw_front.sv
rtl/tccw_queue.sv
rtl/tccw_back.sv
rtl/text_console_char_writer.sv
dv/tb_text_console_char_writer.sv
